### hw/rtl/lsbfr_pkg.sv
// shared types and constants of the lsb-first bit-field reader
package lsbfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int OFF_W   = 3;   // bit offset inside the head byte
  localparam int NEED_W  = 4;   // bytes touched by one read, up to nine
  localparam int CNT_W   = 7;   // field width as carried on the input
  localparam int FIELD_W = 64;
  localparam int ACC_W   = 72;  // nine byte lanes
  localparam int HELD_W  = 5;
  localparam int SPAN_W  = 8;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_READ    = 2'd1,
    OP_ALIGN   = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CNT  = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // command from the sequencer to the gather unit
  typedef struct packed {
    logic              start;
    logic [NEED_W-1:0] need;
    logic [OFF_W-1:0]  off;
    logic [CNT_W-1:0]  count;
  } lsbfr_gctl_t;

  // read request and completion from the gather unit
  typedef struct packed {
    logic              done;
    logic              rd_en;
    logic [NEED_W-1:0] rd_idx;
  } lsbfr_gsts_t;

endpackage

### hw/rtl/lsbfr_ram.sv
// generic single-port-write ram with registered read
module lsbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/lsbfr_gather.sv
// byte gather unit: one queue byte a cycle into a lane, then shift and mask
module lsbfr_gather
  import lsbfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lsbfr_gctl_t        ctl,
  input  logic [BYTE_W-1:0]  rd_data,
  output lsbfr_gsts_t        sts,
  output logic [FIELD_W-1:0] field_value
);

  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  logic              done_r, done_nxt;
  logic [NEED_W-1:0] issue_r, issue_nxt;
  logic [NEED_W-1:0] recv_r, recv_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              rd_en;
  logic [ACC_W-1:0]  shifted;
  logic [FIELD_W-1:0] mask;

  assign rd_en = busy_r && (issue_r < need_r);

  always_comb begin
    busy_nxt  = busy_r;
    pend_nxt  = rd_en;
    done_nxt  = 1'b0;
    issue_nxt = issue_r;
    recv_nxt  = recv_r;
    need_nxt  = need_r;
    off_nxt   = off_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      pend_nxt  = 1'b0;
      issue_nxt = '0;
      recv_nxt  = '0;
      need_nxt  = ctl.need;
      off_nxt   = ctl.off;
      count_nxt = ctl.count;
      acc_nxt   = '0;
    end else begin
      if (rd_en) begin
        issue_nxt = issue_r + 1'b1;
      end
      // registered read data lands in the next byte lane
      if (pend_r) begin
        acc_nxt[{recv_r, 3'b000} +: BYTE_W] = rd_data;
        recv_nxt = recv_r + 1'b1;
        if (recv_nxt == need_r) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      done_r <= done_nxt;
    end
    issue_r <= issue_nxt;
    recv_r  <= recv_nxt;
    need_r  <= need_nxt;
    off_r   <= off_nxt;
    count_r <= count_nxt;
    acc_r   <= acc_nxt;
  end

  // drop the bits already consumed, keep count bits (a count of 64 keeps all)
  assign shifted     = acc_r >> off_r;
  assign mask        = ~({FIELD_W{1'b1}} << count_r);
  assign field_value = shifted[FIELD_W-1:0] & mask;

  assign sts.done   = done_r;
  assign sts.rd_en  = rd_en;
  assign sts.rd_idx = issue_r;

endmodule

### hw/rtl/lsb_first_bit_field_reader_unit.sv
// top level of the lsb-first bit-field reader: queue control, sequencer, result register
//
// LSB-first bit-field reader over a circular byte queue of QUEUE_DEPTH
// entries. Each input item carries an op in in_tuser: push a byte, read a
// field of 1 to MAX_FIELD_BITS bits starting at the current bit offset in
// the head byte, align to the next byte boundary, or restart (optionally
// emptying the queue). Every item gives exactly one result item with the
// field (zero unless a read succeeds), a status code and the number of bytes
// left in the queue. Push, align, restart and rejected reads go from
// acceptance to the finish state and from there into the output register
// once it is free. A good read passes through the gather state first and
// touches need = ceil((bit offset + bit count) / 8) bytes: the gather unit
// fetches one byte per cycle through the single read port of the byte ram,
// then shifts and masks the gathered lanes. One item is in work at a time;
// in_tready is high only while the sequencer is idle, and a finished result
// sits in the output register until taken, so the next item may be accepted
// while it waits. The byte store has no reset; only held bytes are ever read.
module lsb_first_bit_field_reader_unit
  import lsbfr_pkg::*;
#(
  parameter int QUEUE_DEPTH    = 16,
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // byte_in[7:0], bit_count[14:8], clear_buffer[15]
  input  logic [1:0]  in_tuser,  // op[1:0]
  // result item channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata, // field_value[63:0], bytes_held[68:64], zero pad
  output logic [1:0]  out_tuser  // status[1:0]
);

  localparam int AW = $clog2(QUEUE_DEPTH);      // queue address width
  localparam int CW = $clog2(QUEUE_DEPTH + 1);  // fill count width
  localparam logic [CW-1:0]     DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]       DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [SPAN_W-1:0] MAXF_C  = SPAN_W'(MAX_FIELD_BITS);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // queue state
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;

  // item in work
  logic [1:0]        res_status_r, res_status_nxt;
  logic              res_is_read_r, res_is_read_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;

  // output register
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [FIELD_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [HELD_W-1:0]  out_held_r, out_held_nxt;

  // unpacked input fields
  op_t               in_op;
  logic [BYTE_W-1:0] in_byte;
  logic [CNT_W-1:0]  in_count;
  logic              in_clear;
  logic              in_acc;

  // read bookkeeping
  logic [SPAN_W-1:0] span;
  logic [NEED_W-1:0] need;
  logic              bad_count;

  // head advance for pops (up to eight bytes)
  logic [NEED_W-1:0] adv_amt;
  logic [AW:0]       adv_sum;
  logic [AW-1:0]     head_adv;

  // tail address for pushes
  logic [CW:0]       tail_sum;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  // gather read address
  logic [AW:0]       rd_sum;
  logic [AW-1:0]     rd_addr;

  logic [BYTE_W-1:0]  rd_data;
  logic [FIELD_W-1:0] gather_value;
  lsbfr_gctl_t        gctl;
  lsbfr_gsts_t        gsts;

  logic [CW+HELD_W-1:0] held_ext;
  logic                 out_free;

  assign in_op    = op_t'(in_tuser);
  assign in_byte  = in_tdata[7:0];
  assign in_count = in_tdata[14:8];
  assign in_clear = in_tdata[15];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign span      = SPAN_W'(off_r) + SPAN_W'(in_count);
  assign need      = NEED_W'((span + SPAN_W'(7)) >> 3);
  assign bad_count = (in_count == '0) || ({1'b0, in_count} > MAXF_C);

  // circular pointer arithmetic, one compare and subtract for the wrap
  assign adv_sum  = {1'b0, head_r} + (AW + 1)'(adv_amt);
  assign head_adv = (adv_sum >= (AW + 1)'(QUEUE_DEPTH)) ?
                    AW'(adv_sum - (AW + 1)'(QUEUE_DEPTH)) : AW'(adv_sum);

  assign tail_sum = (CW + 1)'(head_r) + {1'b0, count_r};
  assign wr_addr  = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

  assign rd_sum  = {1'b0, head_r} + (AW + 1)'(gsts.rd_idx);
  assign rd_addr = (rd_sum >= (AW + 1)'(QUEUE_DEPTH)) ?
                   AW'(rd_sum - (AW + 1)'(QUEUE_DEPTH)) : AW'(rd_sum);

  assign wr_en = in_acc && (in_op == OP_PUSH) && (count_r < DEPTH_C);

  assign gctl.start = in_acc && (in_op == OP_READ) && !bad_count &&
                      (count_r >= CW'(need));
  assign gctl.need  = need;
  assign gctl.off   = off_r;
  assign gctl.count = in_count;

  assign held_ext = {{HELD_W{1'b0}}, count_r};
  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    off_nxt         = off_r;
    res_status_nxt  = res_status_r;
    res_is_read_nxt = res_is_read_r;
    span_nxt        = span_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_value_nxt   = out_value_r;
    out_status_nxt  = out_status_r;
    out_held_nxt    = out_held_r;
    adv_amt         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt  = ST_OK;
          res_is_read_nxt = 1'b0;
          state_nxt       = S_FINISH;
          case (in_op)
            OP_PUSH: begin
              if (count_r >= DEPTH_C) begin
                res_status_nxt = ST_OVERFLOW;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
            OP_READ: begin
              if (bad_count) begin
                res_status_nxt = ST_BAD_CNT;
              end else if (count_r < CW'(need)) begin
                res_status_nxt = ST_SHORT;
              end else begin
                res_is_read_nxt = 1'b1;
                span_nxt        = span;
                state_nxt       = S_GATHER;
              end
            end
            OP_ALIGN: begin
              // a partly read head byte leaves the queue
              if ((off_r != '0) && (count_r != '0)) begin
                adv_amt   = NEED_W'(1);
                head_nxt  = head_adv;
                count_nxt = count_r - 1'b1;
              end
              off_nxt = '0;
            end
            OP_RESTART: begin
              if (in_clear) begin
                head_nxt  = '0;
                count_nxt = '0;
              end
              off_nxt = '0;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_GATHER: begin
        if (gsts.done) begin
          // pop the whole bytes consumed, carry the rest as bit offset
          adv_amt   = NEED_W'(span_r >> 3);
          head_nxt  = head_adv;
          count_nxt = count_r - CW'(span_r >> 3);
          off_nxt   = span_r[OFF_W-1:0];
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_value_nxt  = res_is_read_r ? gather_value : '0;
          out_status_nxt = res_status_r;
          out_held_nxt   = held_ext[HELD_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      off_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      off_r        <= off_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    res_status_r  <= res_status_nxt;
    res_is_read_r <= res_is_read_nxt;
    span_r        <= span_nxt;
    out_value_r   <= out_value_nxt;
    out_status_r  <= out_status_nxt;
    out_held_r    <= out_held_nxt;
  end

  // byte store
  lsbfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (gsts.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // gather, shift and mask unit for reads
  lsbfr_gather u_gather (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (gctl),
    .rd_data     (rd_data),
    .sts         (gsts),
    .field_value (gather_value)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_held_r, out_value_r};
  assign out_tuser  = out_status_r;

endmodule

### sim/tb_lsb_first_bit_field_reader_unit.sv
// self-checking testbench for the lsb-first bit-field reader: result scoreboard and stream drivers
module tb_lsb_first_bit_field_reader_unit;
  import lsbfr_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int MAX_FIELD_BITS = 64;
  localparam int ITEM_TARGET    = 1325;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [4:0]  held;
  } field_result_t;

  // mirrors the queue, head and bit offset, and keeps the results still owed by the block
  class field_read_board;
    logic [7:0]    byte_store [QUEUE_DEPTH];
    logic [3:0]    head;
    logic [4:0]    held;
    logic [2:0]    offset;
    field_result_t pending_results [$];
    int            mismatches;

    function new();
      head       = '0;
      held       = '0;
      offset     = '0;
      mismatches = 0;
    endfunction

    function void note_item(op_t op, logic [7:0] byte_in, logic [6:0] bit_count, logic clear);
      field_result_t r;
      logic [71:0]   lanes;
      logic [7:0]    span;
      int            need;
      r     = '0;
      lanes = '0;
      case (op)
        OP_PUSH: begin
          if (held >= QUEUE_DEPTH) begin
            r.status = ST_OVERFLOW;
          end else begin
            byte_store[4'(head + held)] = byte_in;
            held = held + 5'd1;
          end
        end
        OP_READ: begin
          span = 8'(offset) + 8'(bit_count);
          need = (int'(span) + 7) / 8;
          if (bit_count == 0 || bit_count > MAX_FIELD_BITS) begin
            r.status = ST_BAD_CNT;
          end else if (held < need) begin
            r.status = ST_SHORT;
          end else begin
            // gather whole byte lanes, then drop the bits already consumed
            for (int i = 0; i < need; i++) lanes[8*i +: 8] = byte_store[4'(head + i)];
            lanes = lanes >> offset;
            if (bit_count < 64) r.value = lanes[63:0] & ((64'd1 << bit_count) - 64'd1);
            else r.value = lanes[63:0];
            head   = head + 4'(span >> 3);
            held   = held - 5'(span >> 3);
            offset = span[2:0];
          end
        end
        OP_ALIGN: begin
          if (offset != 0 && held != 0) begin
            head = head + 4'd1;
            held = held - 5'd1;
          end
          offset = '0;
        end
        default: begin
          if (clear) begin
            head = '0;
            held = '0;
          end
          offset = '0;
        end
      endcase
      r.held = held;
      pending_results.push_back(r);
    endfunction

    function void check_item(logic [71:0] data, logic [1:0] user);
      field_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d held %0d",
                 $time, data[63:0], user, data[68:64]);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (data[63:0] !== want.value) begin
        $display("%0t: field value expected %h actual %h", $time, want.value, data[63:0]);
        mismatches++;
      end
      if (user !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, user);
        mismatches++;
      end
      if (data[68:64] !== want.held) begin
        $display("%0t: bytes held expected %0d actual %0d", $time, want.held, data[68:64]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  field_read_board board = new();
  int              items_sent = 0;
  bit              calm = 1'b0; // when set, neither side idles

  lsb_first_bit_field_reader_unit #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // offers one item after a random gap; valid stays high when the gap is zero
  task automatic send_item(op_t op, logic [7:0] byte_in, logic [6:0] bit_count, logic clear);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {clear, bit_count, byte_in};
    do @(posedge clk); while (!in_tready);
    board.note_item(op, byte_in, bit_count, clear);
    items_sent++;
  endtask

  // result side: random stalls, each accepted item checked against the oldest expectation
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      board.check_item(out_tdata, out_tuser);
    end
  end

  initial begin
    int mode, room, reads, avail, lim, w;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PUSH;
    rst_n     <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue cases, fill to overflow, bad widths, widest read at odd offset
    send_item(OP_RESTART, 8'h00, 7'd0, 1'b1);
    send_item(OP_ALIGN, 8'h00, 7'd0, 1'b0);
    send_item(OP_READ, 8'h00, 7'd1, 1'b0);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_item(OP_PUSH, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'h01 :
                (i == 3) ? 8'h80 : 8'($urandom), 7'd0, 1'b0);
    end
    send_item(OP_PUSH, 8'hFF, 7'd0, 1'b0);
    send_item(OP_READ, 8'h00, 7'd0, 1'b0);
    send_item(OP_READ, 8'h00, 7'd127, 1'b0);
    send_item(OP_READ, 8'h00, 7'd65, 1'b0);
    send_item(OP_READ, 8'h00, 7'd3, 1'b0);
    send_item(OP_READ, 8'h00, 7'd64, 1'b0);
    send_item(OP_ALIGN, 8'h00, 7'd0, 1'b0);
    send_item(OP_ALIGN, 8'h00, 7'd0, 1'b0);
    send_item(OP_READ, 8'h00, 7'd64, 1'b0);
    send_item(OP_RESTART, 8'hFF, 7'd127, 1'b0);

    // random: mostly push runs followed by reads that fit, with noise and broken sequences
    while (items_sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      calm = ($urandom_range(0, 7) == 0);
      if (mode < 7) begin
        room = QUEUE_DEPTH - board.held;
        if (room > 0) begin
          repeat ($urandom_range(1, room))
            send_item(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
        end
        reads = $urandom_range(1, 4);
        repeat (reads) begin
          avail = board.held * 8 - board.offset;
          if (avail > 0) begin
            lim = (avail > MAX_FIELD_BITS) ? MAX_FIELD_BITS : avail;
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: w = $urandom_range(1, (lim < 8) ? lim : 8);
              5, 6, 7:       w = $urandom_range(1, (lim < 24) ? lim : 24);
              default:       w = $urandom_range(1, lim);
            endcase
            send_item(OP_READ, 8'($urandom), 7'(w), 1'($urandom));
          end
        end
        if ($urandom_range(0, 3) == 0) send_item(OP_ALIGN, 8'($urandom), 7'($urandom), 1'($urandom));
      end else if (mode == 7) begin
        repeat ($urandom_range(1, 4))
          send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom), 1'($urandom));
      end else if (mode == 8) begin
        case ($urandom_range(0, 2))
          0: begin
            // one more bit than the queue holds, or more, as the low seven bits of the count
            avail = board.held * 8 - board.offset;
            send_item(OP_READ, 8'($urandom), 7'(avail + $urandom_range(1, 8)), 1'($urandom));
          end
          1: send_item(OP_READ, 8'($urandom),
                       $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127)), 1'($urandom));
          default: begin
            while (board.held < QUEUE_DEPTH)
              send_item(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
            send_item(OP_PUSH, 8'($urandom), 7'($urandom), 1'($urandom));
          end
        endcase
      end else begin
        send_item(OP_RESTART, 8'($urandom), 7'($urandom), 1'($urandom));
      end
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    // any stray result would still be caught by the checker here
    repeat (30) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
hw/rtl/lsbfr_pkg.sv
hw/rtl/lsbfr_ram.sv
hw/rtl/lsbfr_gather.sv
hw/rtl/lsb_first_bit_field_reader_unit.sv
sim/tb_lsb_first_bit_field_reader_unit.sv
